### hw/rtl/hamming_single_error_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// Hamming decoder assertion macros
// Concurrent assertion forms used by the decoder correction stage.
// ----------------------------------------------------------------------------
`ifndef HAMMING_SINGLE_ERROR_DECODER_TOP_DEFINES_SVH
`define HAMMING_SINGLE_ERROR_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define HSED_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsed: same-cycle check failed");

// Next-cycle implication, sampled at the rising clock edge.
`define HSED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsed: next-cycle check failed");

`endif

### hw/rtl/hsed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hamming decoder package
// Field widths, register codes and constant position tables.
// ----------------------------------------------------------------------------
package hsed_pkg;

   localparam int WORD_BITS  = 64;
   localparam int LEN_BITS   = 7;
   localparam int SYN_BITS   = 7;
   localparam int DATA_BITS  = 57;
   localparam int COUNT_BITS = 6;
   localparam int MIN_LEN    = 3;

   typedef enum logic {
      REG_CODE_LENGTH = 1'b0,
      REG_ODD_PARITY  = 1'b1
   } reg_index_type;

   // Effective configuration carried along with each request.
   typedef struct packed {
      logic [LEN_BITS-1:0] length;
      logic                odd;
   } cfg_type;

   // Bits of the word covered by check bit b (position k held in bit k-1).
   function automatic logic [WORD_BITS-1:0] cover_mask(input int b);
      logic [WORD_BITS-1:0] m;
      m = '0;
      for (int k = 1; k <= WORD_BITS; k++) begin
         if (((k >> b) & 1) != 0) m[k-1] = 1'b1;
      end
      return m;
   endfunction

   // Word bit that holds data bit j (j-th non-power-of-two position).
   function automatic logic [5:0] data_pos(input int j);
      logic [5:0] pos;
      int         cnt;
      pos = '0;
      cnt = 0;
      for (int k = 1; k <= WORD_BITS; k++) begin
         if ((k & (k - 1)) != 0) begin
            if (cnt == j) pos = 6'(k - 1);
            cnt++;
         end
      end
      return pos;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/hsed_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hamming decoder channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface hsed_req_if;
   logic                            valid;
   logic                            ready;
   logic [hsed_pkg::WORD_BITS-1:0]  codeword;

   modport source (output valid, output codeword, input ready);
   modport sink   (input valid, input codeword, output ready);
endinterface

interface hsed_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [hsed_pkg::SYN_BITS-1:0]    syndrome;
   logic                             error_found;
   logic                             position_invalid;
   logic [hsed_pkg::WORD_BITS-1:0]   corrected_word;
   logic [hsed_pkg::DATA_BITS-1:0]   data_word;
   logic [hsed_pkg::COUNT_BITS-1:0]  data_count;

   modport source (output valid, output syndrome, output error_found,
                   output position_invalid, output corrected_word,
                   output data_word, output data_count, input ready);
   modport sink   (input valid, input syndrome, input error_found,
                   input position_invalid, input corrected_word,
                   input data_word, input data_count, output ready);
endinterface
`default_nettype wire

### hw/rtl/hamming_single_error_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hamming single-error-correcting decoder
// Three-stage pipelined syndrome decoder with an APB-style register port.
// ----------------------------------------------------------------------------
// Each request carries one codeword (position k in bit k-1). The block masks
// it to the configured length, forms the parity checks, flips the bit the
// syndrome points at and returns syndrome, flags, corrected word and packed
// data bits. Three register stages (mask, syndrome, correction) lie between
// the request and the response. One request is accepted every cycle unless
// a response that is not taken has backed the stages up; each stage whose
// register is empty keeps taking requests while a later one holds a response
// that is not yet taken, so bubbles fill up. A syndrome
// beyond the length raises position_invalid together with error_found and
// leaves the word untouched. code_length saturates into the range 3 to
// MAX_CODE_BITS. Registers: code_length at byte 0, odd_parity at byte 4;
// write them only while no request is in flight. There is no clearing pass
// after reset.
module hamming_single_error_decoder_top #(
   parameter int MAX_CODE_BITS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   hsed_req_if.sink         req,
   hsed_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   localparam int W = MAX_CODE_BITS;

   // Configuration registers.
   logic [hsed_pkg::LEN_BITS-1:0] code_length_ff, code_length_in;
   logic                          odd_parity_ff, odd_parity_in;
   logic                          csr_write;
   hsed_pkg::reg_index_type       csr_index;
   hsed_pkg::cfg_type             cfg;

   // Inter-stage handshakes.
   logic                          s1_valid, s1_ready;
   hsed_pkg::cfg_type             s1_cfg;
   logic [W-1:0]                  s1_word;
   logic                          s2_valid, s2_ready;
   hsed_pkg::cfg_type             s2_cfg;
   logic [W-1:0]                  s2_word;
   logic [hsed_pkg::SYN_BITS-1:0] s2_syndrome;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = hsed_pkg::reg_index_type'(csr_paddr[2]);

   // Decode the write address and hold the other register.
   always_comb begin
      code_length_in = code_length_ff;
      odd_parity_in  = odd_parity_ff;
      if (csr_write) begin
         unique case (csr_index)
            hsed_pkg::REG_CODE_LENGTH: begin
               code_length_in = csr_pwdata[hsed_pkg::LEN_BITS-1:0];
            end
            hsed_pkg::REG_ODD_PARITY: begin
               odd_parity_in = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_length_ff <= hsed_pkg::LEN_BITS'(hsed_pkg::WORD_BITS);
         odd_parity_ff  <= 1'b0;
      end else begin
         code_length_ff <= code_length_in;
         odd_parity_ff  <= odd_parity_in;
      end
   end

   // Return the stored register values on reads.
   always_comb begin
      unique case (csr_index)
         hsed_pkg::REG_CODE_LENGTH: csr_prdata = 32'(code_length_ff);
         hsed_pkg::REG_ODD_PARITY:  csr_prdata = 32'(odd_parity_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Saturate the length into the supported range.
   always_comb begin
      cfg.odd = odd_parity_ff;
      if (code_length_ff > hsed_pkg::LEN_BITS'(W)) begin
         cfg.length = hsed_pkg::LEN_BITS'(W);
      end else if (code_length_ff < hsed_pkg::LEN_BITS'(hsed_pkg::MIN_LEN)) begin
         cfg.length = hsed_pkg::LEN_BITS'(hsed_pkg::MIN_LEN);
      end else begin
         cfg.length = code_length_ff;
      end
   end

   // Stage one: drop bits beyond the length.
   hsed_mask #(.W(W)) u_mask (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req.valid),
      .in_ready    (req.ready),
      .in_cfg      (cfg),
      .in_codeword (req.codeword),
      .out_valid   (s1_valid),
      .out_ready   (s1_ready),
      .out_cfg     (s1_cfg),
      .out_word    (s1_word)
   );

   // Stage two: parity checks into the syndrome.
   hsed_syndrome #(.W(W)) u_syndrome (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid),
      .in_ready     (s1_ready),
      .in_cfg       (s1_cfg),
      .in_word      (s1_word),
      .out_valid    (s2_valid),
      .out_ready    (s2_ready),
      .out_cfg      (s2_cfg),
      .out_word     (s2_word),
      .out_syndrome (s2_syndrome)
   );

   // Stage three: correction, data extraction and the response register.
   hsed_correct #(.W(W)) u_correct (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (s2_valid),
      .in_ready             (s2_ready),
      .in_cfg               (s2_cfg),
      .in_word              (s2_word),
      .in_syndrome          (s2_syndrome),
      .out_valid            (rsp.valid),
      .out_ready            (rsp.ready),
      .out_syndrome         (rsp.syndrome),
      .out_error_found      (rsp.error_found),
      .out_position_invalid (rsp.position_invalid),
      .out_corrected_word   (rsp.corrected_word),
      .out_data_word        (rsp.data_word),
      .out_data_count       (rsp.data_count)
   );

endmodule
`default_nettype wire

### hw/rtl/hsed_mask.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hamming decoder mask stage
// Clear codeword bits beyond the code length and register the request.
// ----------------------------------------------------------------------------
module hsed_mask #(
   parameter int W = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output      logic                           in_ready,
   input  wire hsed_pkg::cfg_type              in_cfg,
   input  wire logic [hsed_pkg::WORD_BITS-1:0] in_codeword,
   output      logic                           out_valid,
   input  wire logic                           out_ready,
   output      hsed_pkg::cfg_type              out_cfg,
   output      logic [W-1:0]                   out_word
);

   logic              valid_ff, valid_in;
   hsed_pkg::cfg_type cfg_ff;
   logic [W-1:0]      word_ff, word_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      for (int k = 0; k < W; k++) begin
         word_in[k] = in_codeword[k] &
                      (hsed_pkg::LEN_BITS'(k + 1) <= in_cfg.length);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cfg_ff  <= in_cfg;
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_cfg   = cfg_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

### hw/rtl/hsed_syndrome.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hamming decoder syndrome stage
// Form the parity checks of the masked word and register the syndrome.
// ----------------------------------------------------------------------------
module hsed_syndrome #(
   parameter int W = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire hsed_pkg::cfg_type             in_cfg,
   input  wire logic [W-1:0]                  in_word,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      hsed_pkg::cfg_type             out_cfg,
   output      logic [W-1:0]                  out_word,
   output      logic [hsed_pkg::SYN_BITS-1:0] out_syndrome
);

   logic                          valid_ff, valid_in;
   hsed_pkg::cfg_type             cfg_ff;
   logic [W-1:0]                  word_ff;
   logic [hsed_pkg::SYN_BITS-1:0] syn_ff, syn_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Only checks whose position lies inside the code length take part.
   always_comb begin
      logic [hsed_pkg::WORD_BITS-1:0] cov;
      syn_in = '0;
      for (int b = 0; b < hsed_pkg::SYN_BITS; b++) begin
         cov = hsed_pkg::cover_mask(b);
         if ((8'd1 << b) <= {1'b0, in_cfg.length}) begin
            syn_in[b] = in_cfg.odd ^ (^(in_word & cov[W-1:0]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cfg_ff  <= in_cfg;
         word_ff <= in_word;
         syn_ff  <= syn_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_cfg      = cfg_ff;
   assign out_word     = word_ff;
   assign out_syndrome = syn_ff;

endmodule
`default_nettype wire

### hw/rtl/hsed_correct.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hamming decoder correction stage
// Flip the flagged bit, extract the data bits and hold the response.
// ----------------------------------------------------------------------------
`include "hamming_single_error_decoder_top_defines.svh"

module hsed_correct #(
   parameter int W = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output      logic                            in_ready,
   input  wire hsed_pkg::cfg_type               in_cfg,
   input  wire logic [W-1:0]                    in_word,
   input  wire logic [hsed_pkg::SYN_BITS-1:0]   in_syndrome,
   output      logic                            out_valid,
   input  wire logic                            out_ready,
   output      logic [hsed_pkg::SYN_BITS-1:0]   out_syndrome,
   output      logic                            out_error_found,
   output      logic                            out_position_invalid,
   output      logic [hsed_pkg::WORD_BITS-1:0]  out_corrected_word,
   output      logic [hsed_pkg::DATA_BITS-1:0]  out_data_word,
   output      logic [hsed_pkg::COUNT_BITS-1:0] out_data_count
);

   logic                            valid_ff, valid_in;
   logic [hsed_pkg::LEN_BITS-1:0]   len_ff;
   logic [hsed_pkg::SYN_BITS-1:0]   syn_ff;
   logic                            err_ff, err_in;
   logic                            inv_ff, inv_in;
   logic [W-1:0]                    word_ff, word_in;
   logic [hsed_pkg::DATA_BITS-1:0]  data_ff, data_in;
   logic [hsed_pkg::COUNT_BITS-1:0] count_ff, count_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign err_in = (in_syndrome != '0);
   assign inv_in = err_in && ({1'b0, in_syndrome} > {1'b0, in_cfg.length});

   always_comb begin
      logic [hsed_pkg::WORD_BITS-1:0] wide;
      logic [2:0]                     pow_cnt;
      for (int k = 0; k < W; k++) begin
         word_in[k] = in_word[k] ^
                      (err_in && !inv_in &&
                       (in_syndrome == hsed_pkg::SYN_BITS'(k + 1)));
      end
      // Data positions are fixed; bits beyond the length are already zero.
      wide = hsed_pkg::WORD_BITS'(word_in);
      for (int j = 0; j < hsed_pkg::DATA_BITS; j++) begin
         data_in[j] = wide[hsed_pkg::data_pos(j)];
      end
      pow_cnt = '0;
      for (int b = 0; b < hsed_pkg::LEN_BITS; b++) begin
         if ((8'd1 << b) <= {1'b0, in_cfg.length}) pow_cnt = pow_cnt + 3'd1;
      end
      count_in = hsed_pkg::COUNT_BITS'(in_cfg.length - hsed_pkg::LEN_BITS'(pow_cnt));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         len_ff   <= in_cfg.length;
         syn_ff   <= in_syndrome;
         err_ff   <= err_in;
         inv_ff   <= inv_in;
         word_ff  <= word_in;
         data_ff  <= data_in;
         count_ff <= count_in;
      end
   end

   assign out_valid            = valid_ff;
   assign out_syndrome         = syn_ff;
   assign out_error_found      = err_ff;
   assign out_position_invalid = inv_ff;
   assign out_corrected_word   = hsed_pkg::WORD_BITS'(word_ff);
   assign out_data_word        = data_ff;
   assign out_data_count       = count_ff;

   `HSED_ASSERT_IMPLIES(a_inv_has_err, clock, reset, valid_ff && inv_ff, err_ff)
   `HSED_ASSERT_IMPLIES(a_clean_zero_syn, clock, reset, valid_ff && !err_ff,
                        syn_ff == '0 && !inv_ff)
   `HSED_ASSERT_IMPLIES(a_valid_in_len, clock, reset, valid_ff && !inv_ff,
                        {1'b0, syn_ff} <= {1'b0, len_ff})
   `HSED_ASSERT_IMPLIES(a_upper_zero, clock, reset, valid_ff,
                        (hsed_pkg::WORD_BITS'(word_ff) >> len_ff) == '0)
   `HSED_ASSERT_NEXT(a_load_shows, clock, reset, in_valid && in_ready, valid_ff)

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamming single-error decoder testbench
// Streams codewords through the decoder under several length and parity
// settings, predicts syndrome, flags, corrected word and packed data bits
// for every request, and checks each response in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_CODE_BITS = 64;
   localparam int LONG_HOLD     = 120;

   typedef struct packed {
      logic [hsed_pkg::SYN_BITS-1:0]   syndrome;
      logic                            error_found;
      logic                            position_invalid;
      logic [hsed_pkg::WORD_BITS-1:0]  corrected_word;
      logic [hsed_pkg::DATA_BITS-1:0]  data_word;
      logic [hsed_pkg::COUNT_BITS-1:0] data_count;
   } decode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   hsed_req_if req_bus ();
   hsed_rsp_if rsp_bus ();

   hamming_single_error_decoder_top #(
      .MAX_CODE_BITS(MAX_CODE_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the decoder registers, as last written.
   logic [hsed_pkg::LEN_BITS-1:0] shadow_length = 7'd64;
   logic                          shadow_odd = 1'b0;

   logic [hsed_pkg::WORD_BITS-1:0] codeword_queue[$];
   decode_type                     outstanding_decodes[$];
   int                             requests_offered = 0;
   int                             requests_accepted = 0;
   int                             errors = 0;

   // Idle controls shared by the stimulus and the two channel processes.
   bit sender_burst = 1'b0;
   bit sink_burst = 1'b0;
   int hold_off_requests = 0;

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------

   // Clamp the programmed length into the range the decoder supports.
   function automatic int unsigned active_length();
      int unsigned n;
      n = shadow_length;
      if (n > MAX_CODE_BITS) n = MAX_CODE_BITS;
      if (n < hsed_pkg::MIN_LEN) n = hsed_pkg::MIN_LEN;
      return n;
   endfunction

   function automatic logic [hsed_pkg::WORD_BITS-1:0] length_mask(int unsigned n);
      if (n >= hsed_pkg::WORD_BITS) return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   // Sum of the failing check positions; position k lives in bit k-1.
   function automatic logic [hsed_pkg::SYN_BITS-1:0] parity_syndrome(
         logic [hsed_pkg::WORD_BITS-1:0] word, int unsigned n, logic odd);
      logic [hsed_pkg::SYN_BITS-1:0] syn;
      logic                          chk;
      syn = '0;
      for (int unsigned p = 1; p <= n; p = p << 1) begin
         chk = odd;
         for (int unsigned k = 1; k <= n; k++) begin
            if ((k & p) != 0) chk ^= word[k-1];
         end
         if (chk) syn += hsed_pkg::SYN_BITS'(p);
      end
      return syn;
   endfunction

   function automatic decode_type decode_codeword(logic [hsed_pkg::WORD_BITS-1:0] codeword);
      decode_type                     res;
      int unsigned                    n;
      int unsigned                    cnt;
      logic [hsed_pkg::WORD_BITS-1:0] word;
      logic [hsed_pkg::DATA_BITS-1:0] data;
      n = active_length();
      word = codeword & length_mask(n);
      res.syndrome = parity_syndrome(word, n, shadow_odd);
      res.error_found = res.syndrome != 0;
      res.position_invalid = res.syndrome > n;
      // Flip the pointed-at bit only when it lies inside the code.
      if (res.error_found && !res.position_invalid) word[res.syndrome-1] = ~word[res.syndrome-1];
      data = '0;
      cnt = 0;
      for (int unsigned k = 1; k <= n; k++) begin
         if ((k & (k - 1)) != 0) begin
            data[cnt] = word[k-1];
            cnt++;
         end
      end
      res.corrected_word = word;
      res.data_word = data;
      res.data_count = hsed_pkg::COUNT_BITS'(cnt);
      return res;
   endfunction

   // Build a clean codeword at the current length and parity from random content.
   function automatic logic [hsed_pkg::WORD_BITS-1:0] encode_codeword(
         logic [hsed_pkg::WORD_BITS-1:0] raw);
      logic [hsed_pkg::WORD_BITS-1:0] word;
      logic [hsed_pkg::SYN_BITS-1:0]  syn;
      int unsigned                    n;
      n = active_length();
      word = raw & length_mask(n);
      for (int unsigned p = 1; p <= n; p = p << 1) word[p-1] = 1'b0;
      // Each check position is covered by its own check only, so set it to cancel.
      syn = parity_syndrome(word, n, shadow_odd);
      for (int unsigned p = 1; p <= n; p = p << 1) begin
         if ((syn & p) != 0) word[p-1] = 1'b1;
      end
      return word;
   endfunction

   function automatic logic [hsed_pkg::WORD_BITS-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Append one codeword to the pending requests.
   function automatic void enqueue_word(logic [hsed_pkg::WORD_BITS-1:0] word);
      codeword_queue.insert(codeword_queue.size(), word);
   endfunction

   // Mostly back-to-back, sometimes a short pause, rarely a long one.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic bit field_ok(string name, logic [hsed_pkg::WORD_BITS-1:0] want,
                                   logic [hsed_pkg::WORD_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: present codewords at the falling edge, hold until taken
   // ------------------------------------------------------------------------
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (requests_offered == requests_accepted) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (codeword_queue.size() != 0) begin
            req_bus.codeword <= codeword_queue.pop_front();
            req_bus.valid <= 1'b1;
            requests_offered++;
            gap_left = sender_burst ? 0 : idle_cycles();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      // Otherwise the request is still pending: hold valid and payload.
   end

   // ------------------------------------------------------------------------
   // Response sink: random stalls plus an occasional long hold-off
   // ------------------------------------------------------------------------
   int stall_left = 0;
   int hold_off_served = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_served != hold_off_requests) begin
         // Drop ready for a long stretch so the pipeline fills and backs up.
         hold_off_served++;
         stall_left = LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = sink_burst ? 0 : idle_cycles();
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check responses first, then record newly accepted requests
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      decode_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (outstanding_decodes.size() == 0) begin
               $display("%0t: response with no request waiting, syndrome %h word %h",
                        $time, rsp_bus.syndrome, rsp_bus.corrected_word);
               errors++;
            end else begin
               want = outstanding_decodes.pop_front();
               if (!field_ok("syndrome", want.syndrome, rsp_bus.syndrome)) errors++;
               if (!field_ok("error_found", want.error_found, rsp_bus.error_found)) errors++;
               if (!field_ok("position_invalid", want.position_invalid,
                             rsp_bus.position_invalid)) errors++;
               if (!field_ok("corrected_word", want.corrected_word,
                             rsp_bus.corrected_word)) errors++;
               if (!field_ok("data_word", want.data_word, rsp_bus.data_word)) errors++;
               if (!field_ok("data_count", want.data_count, rsp_bus.data_count)) errors++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            outstanding_decodes.insert(outstanding_decodes.size(),
                                       decode_codeword(req_bus.codeword));
            requests_accepted++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Register write in a setup and an access phase; the shadow copy follows once the access is done.
   task automatic csr_write(hsed_pkg::reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         hsed_pkg::REG_CODE_LENGTH: shadow_length = value[hsed_pkg::LEN_BITS-1:0];
         hsed_pkg::REG_ODD_PARITY: shadow_odd = value[0];
         default: ;
      endcase
   endtask

   // Hold until every queued request is taken and every response checked.
   task automatic wait_drained();
      while (codeword_queue.size() != 0 || requests_offered != requests_accepted ||
             outstanding_decodes.size() != 0) @(posedge clock);
   endtask

   // Corner codewords at the current setting: patterns, single errors at
   // both ends and on a check position, and a double error whose syndrome
   // points past the end of a full-length code.
   task automatic push_directed();
      logic [hsed_pkg::WORD_BITS-1:0] clean;
      int unsigned                    n;
      n = active_length();
      clean = encode_codeword(random_word());
      enqueue_word('0);
      enqueue_word('1);
      enqueue_word({32{2'b01}});
      enqueue_word({32{2'b10}});
      enqueue_word(clean);
      enqueue_word(clean ^ 64'd1);
      enqueue_word(clean ^ (64'd1 << (n - 1)));
      enqueue_word(clean ^ (64'd1 << 31));
      enqueue_word(clean ^ 64'd1 ^ (64'd1 << (n - 1)));
      enqueue_word(clean ^ (64'd1 << 4));
   endtask

   // Mostly well-formed codewords with zero, one or two flipped bits, some
   // raw noise, and random junk above the code length half of the time.
   task automatic push_random(int count);
      logic [hsed_pkg::WORD_BITS-1:0] word;
      int unsigned                    n;
      int unsigned                    a;
      int                             r;
      n = active_length();
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         word = encode_codeword(random_word());
         a = $urandom_range(0, n - 1);
         if (r >= 50 && r < 82) begin
            word[a] = ~word[a];
         end else if (r >= 82 && r < 92) begin
            word[a] = ~word[a];
            a = (a + $urandom_range(1, n - 1)) % n;
            word[a] = ~word[a];
         end else if (r >= 92) begin
            word = random_word();
         end
         if ($urandom_range(0, 1)) word |= random_word() & ~length_mask(n);
         enqueue_word(word);
      end
   endtask

   // Program both registers (junk in the unused upper bits), then stream.
   task automatic run_setting(logic [hsed_pkg::LEN_BITS-1:0] length, logic odd, int count,
                              bit squeeze);
      logic [31:0] value;
      value = $urandom;
      value[hsed_pkg::LEN_BITS-1:0] = length;
      csr_write(hsed_pkg::REG_CODE_LENGTH, value);
      value = $urandom;
      value[0] = odd;
      csr_write(hsed_pkg::REG_ODD_PARITY, value);
      sender_burst = squeeze || ($urandom_range(0, 3) == 0);
      sink_burst = !squeeze && ($urandom_range(0, 3) == 0);
      push_random(count);
      // Stall the sink while the sender keeps offering at full rate.
      if (squeeze) hold_off_requests++;
      wait_drained();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.codeword = '0;
      rsp_bus.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corners at the reset setting: full length, even parity.
      push_directed();
      wait_drained();

      // Out-of-range length saturates to the full code; odd parity turns an
      // all-zero word into the largest syndrome.
      csr_write(hsed_pkg::REG_ODD_PARITY, 32'd1);
      csr_write(hsed_pkg::REG_CODE_LENGTH, 32'd127);
      enqueue_word('0);
      enqueue_word('1);
      enqueue_word(encode_codeword(random_word()));
      enqueue_word(encode_codeword(random_word()) ^ (64'd1 << 6));
      wait_drained();

      run_setting(7'd7, 1'b0, 33, 1'b0);
      run_setting(7'd3, 1'b1, 33, 1'b0);
      run_setting(7'd64, 1'b1, 40, 1'b1);
      run_setting(7'd0, 1'b0, 33, 1'b0);
      run_setting(7'd2, 1'b1, 33, 1'b0);
      run_setting(7'd1, 1'b0, 25, 1'b0);
      run_setting(7'd127, 1'b0, 33, 1'b0);
      run_setting(7'd65, 1'b1, 33, 1'b0);
      run_setting(7'd8, 1'b0, 33, 1'b0);
      run_setting(7'd63, 1'b1, 33, 1'b0);
      run_setting(7'd32, 1'b0, 33, 1'b0);
      run_setting(7'd16, 1'b1, 33, 1'b0);
      run_setting(7'd33, 1'b0, 33, 1'b0);
      for (int i = 0; i < 3; i++) begin
         run_setting(hsed_pkg::LEN_BITS'($urandom_range(3, 64)), 1'($urandom), 33, 1'b0);
      end
      run_setting(7'd64, 1'b0, 30, 1'b0);

      // Let the pipeline settle so a stray extra response would show up.
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### hamming_single_error_decoder_top.f
+incdir+hw/rtl
hw/rtl/hsed_pkg.sv
hw/rtl/hsed_ifs.sv
hw/rtl/hsed_mask.sv
hw/rtl/hsed_syndrome.sv
hw/rtl/hsed_correct.sv
hw/rtl/hamming_single_error_decoder_top.sv
dv/testbench.sv
